FILE: hdl/sample_level_player_assert.svh
// Assertion macros for the sample level player.
// IMP: antecedent implies consequent in the same cycle.
// NXT: antecedent implies consequent in the next cycle.
`ifndef SAMPLE_LEVEL_PLAYER_ASSERT_SVH
`define SAMPLE_LEVEL_PLAYER_ASSERT_SVH

`ifndef SYNTH
`define SLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SLP_ASSERT_IMP(lbl, ante, cons, msg)
`define SLP_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/slp_pkg.sv
package slp_pkg;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  localparam logic [1:0] ST_STOPPED  = 2'd0;
  localparam logic [1:0] ST_STALLED  = 2'd1;
  localparam logic [1:0] ST_PLAYING  = 2'd2;
  localparam logic [1:0] ST_STOPPING = 2'd3;

  localparam logic [1:0] REG_GAIN           = 2'd0;
  localparam logic [1:0] REG_NUM_LEVELS     = 2'd1;
  localparam logic [1:0] REG_BUFFER_SAMPLES = 2'd2;

  localparam logic [15:0] GAIN_RESET           = 16'd4096;
  localparam logic [6:0]  NUM_LEVELS_RESET     = 7'd4;
  localparam logic [12:0] BUFFER_SAMPLES_RESET = 13'd4096;

  localparam logic signed [32:0] ROUND_BIAS = 33'sd134217728;
  localparam logic [39:0]        SCALE_BIAS = 40'd134217728;
  localparam int                 SCALE_SHIFT = 28;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               used;
    logic               idle;
    logic               taken;
    logic               released;
    logic [1:0]         state;
  } cmd_t;

  typedef struct packed {
    logic [6:0] level;
    logic       used;
    logic       idle;
    logic       taken;
    logic       released;
    logic [1:0] state;
  } res_t;

endpackage

FILE: hdl/slp_fifo.sv
module slp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/slp_front.sv
module slp_front #(
  parameter int MAX_BUFFER_SAMPLES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          action,
  input  logic                buffer_ready,
  input  logic signed [15:0]  sample,
  input  logic [12:0]         buffer_samples,
  output slp_pkg::cmd_t       cmd
);
  import slp_pkg::*;

  localparam int POS_W = $clog2(MAX_BUFFER_SAMPLES + 1);
  localparam int CMP_W = (POS_W > 13) ? POS_W : 13;

  logic [1:0]       play_state;
  logic [1:0]       play_state_next;
  logic [POS_W-1:0] read_position;
  logic [POS_W-1:0] read_position_next;
  logic             holding;
  logic             holding_next;
  logic [CMP_W-1:0] bs_ext;
  logic [POS_W-1:0] size;
  logic [POS_W-1:0] pos_mid;
  logic             hold_mid;

  assign bs_ext = CMP_W'(buffer_samples);

  always_comb begin
    if (bs_ext == '0) begin
      size = POS_W'(1);
    end else if (bs_ext > CMP_W'(MAX_BUFFER_SAMPLES)) begin
      size = POS_W'(MAX_BUFFER_SAMPLES);
    end else begin
      size = POS_W'(bs_ext);
    end
  end

  always_comb begin
    play_state_next    = play_state;
    read_position_next = read_position;
    holding_next       = holding;
    pos_mid            = read_position;
    hold_mid           = holding;
    cmd                = '0;
    cmd.sample         = sample;
    unique case (action)
      ACT_START: begin
        play_state_next    = ST_STALLED;
        read_position_next = size;
      end
      ACT_STOP: begin
        if (play_state == ST_STALLED || play_state == ST_PLAYING) begin
          play_state_next = ST_STOPPING;
        end
      end
      ACT_TICK: begin
        if (play_state != ST_STOPPED) begin
          if (!holding || read_position >= size) begin
            cmd.released = holding;
            hold_mid     = 1'b0;
            if (buffer_ready) begin
              cmd.taken = 1'b1;
              hold_mid  = 1'b1;
              pos_mid   = '0;
              if (play_state == ST_STALLED) begin
                play_state_next = ST_PLAYING;
              end
            end else if (play_state == ST_STOPPING) begin
              play_state_next = ST_STOPPED;
              cmd.idle        = 1'b1;
            end else if (play_state == ST_PLAYING) begin
              play_state_next = ST_STALLED;
              cmd.idle        = 1'b1;
            end
          end
          holding_next       = hold_mid;
          read_position_next = pos_mid;
          if (hold_mid && pos_mid < size) begin
            cmd.used           = 1'b1;
            read_position_next = pos_mid + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    cmd.state = play_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play_state    <= ST_STOPPED;
      read_position <= '0;
      holding       <= 1'b0;
    end else if (accept) begin
      play_state    <= play_state_next;
      read_position <= read_position_next;
      holding       <= holding_next;
    end
  end

endmodule

FILE: hdl/slp_back.sv
module slp_back #(
  parameter int MAX_LEVELS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  slp_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  input  logic [15:0]   gain,
  input  logic [6:0]    num_levels,
  input  logic          res_pop,
  output slp_pkg::res_t res,
  output logic          res_empty
);
  import slp_pkg::*;
  `include "sample_level_player_assert.svh"

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_MUL   = 2'd1;
  localparam logic [1:0] B_SCALE = 2'd2;
  localparam logic [1:0] B_ROUND = 2'd3;

  logic [1:0]         state;
  logic [1:0]         state_next;
  cmd_t               cmd_r;
  logic signed [32:0] prod;
  logic [38:0]        x;
  logic [6:0]         n_eff;
  logic [39:0]        x_round;
  logic [11:0]        lv;
  logic               res_push;
  logic               res_full;
  res_t               res_in;

  assign n_eff = (int'(num_levels) > MAX_LEVELS) ? 7'(MAX_LEVELS) : num_levels;

  assign cmd_pop  = (state == B_IDLE) && !cmd_empty && !res_full;
  assign res_push = (state == B_ROUND);

  assign x_round = {1'b0, x} + SCALE_BIAS;
  assign lv      = x_round[SCALE_SHIFT +: 12];

  always_comb begin
    res_in          = '0;
    res_in.used     = cmd_r.used;
    res_in.idle     = cmd_r.idle;
    res_in.taken    = cmd_r.taken;
    res_in.released = cmd_r.released;
    res_in.state    = cmd_r.state;
    if (cmd_r.used && prod > 0) begin
      res_in.level = (lv > 12'(n_eff)) ? n_eff : lv[6:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (cmd_pop) state_next = B_MUL;
      B_MUL:   state_next = B_SCALE;
      B_SCALE: state_next = B_ROUND;
      B_ROUND: state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd;
    end
    if (state == B_MUL) begin
      prod <= {{17{cmd_r.sample[15]}}, cmd_r.sample} * $signed({17'b0, gain}) + ROUND_BIAS;
    end
    if (state == B_SCALE) begin
      x <= prod[31:0] * n_eff;
    end
  end

  slp_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res_in),
    .full  (res_full),
    .rd    (res_pop),
    .rdata (res),
    .empty (res_empty)
  );

  `SLP_ASSERT_IMP(a_push_room, res_push, !res_full, "result pushed into full queue")
  `SLP_ASSERT_IMP(a_unused_zero, res_push && !res_in.used, res_in.level == '0, "level without sample")
  `SLP_ASSERT_IMP(a_level_clamp, res_push, res_in.level <= n_eff, "level above full scale")
  `SLP_ASSERT_NXT(a_take_runs, cmd_pop, state == B_MUL, "request taken but back end idle")

endmodule

FILE: hdl/sample_level_player.sv
// An accepted request goes through the request queue and the back end's MUL, SCALE and ROUND
// states to the head of the output queue; the back end takes no new request until that one is
// pushed, and a 2-entry request queue absorbs short bursts at one per cycle while not full.
// Reset: synchronous rst returns to stopped, no buffer held, position zero, empties both
// queues and loads gain 4096, num_levels 4, buffer_samples 4096.
module sample_level_player #(
  parameter int MAX_BUFFER_SAMPLES = 4096,
  parameter int MAX_LEVELS         = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         action,
  input  logic               buffer_ready,
  input  logic signed [15:0] sample,
  output logic               empty,
  input  logic               pop,
  output logic [6:0]         level,
  output logic               sample_used,
  output logic               all_idle,
  output logic               buffer_taken,
  output logic               buffer_released,
  output logic [1:0]         player_state,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [15:0]        wr_data
);
  import slp_pkg::*;

  logic [15:0] gain;
  logic [6:0]  num_levels;
  logic [12:0] buffer_samples;
  logic        accept;
  cmd_t        front_cmd;
  cmd_t        back_cmd;
  logic        cmd_empty;
  logic        cmd_pop;
  res_t        res;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain           <= GAIN_RESET;
      num_levels     <= NUM_LEVELS_RESET;
      buffer_samples <= BUFFER_SAMPLES_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_GAIN:           gain           <= wr_data;
        REG_NUM_LEVELS:     num_levels     <= wr_data[6:0];
        REG_BUFFER_SAMPLES: buffer_samples <= wr_data[12:0];
        default: begin
        end
      endcase
    end
  end

  slp_front #(
    .MAX_BUFFER_SAMPLES (MAX_BUFFER_SAMPLES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .action         (action),
    .buffer_ready   (buffer_ready),
    .sample         (sample),
    .buffer_samples (buffer_samples),
    .cmd            (front_cmd)
  );

  slp_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wdata (front_cmd),
    .full  (full),
    .rd    (cmd_pop),
    .rdata (back_cmd),
    .empty (cmd_empty)
  );

  slp_back #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (back_cmd),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .gain       (gain),
    .num_levels (num_levels),
    .res_pop    (pop),
    .res        (res),
    .res_empty  (empty)
  );

  assign level           = res.level;
  assign sample_used     = res.used;
  assign all_idle        = res.idle;
  assign buffer_taken    = res.taken;
  assign buffer_released = res.released;
  assign player_state    = res.state;

endmodule

FILE: tb/sv/player_checker.sv
`timescale 1ns / 100ps
module player_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic [1:0]         action,
  input  logic               buffer_ready,
  input  logic signed [15:0] sample,
  input  logic               empty,
  input  logic               pop,
  input  logic [6:0]         level,
  input  logic               sample_used,
  input  logic               all_idle,
  input  logic               buffer_taken,
  input  logic               buffer_released,
  input  logic [1:0]         player_state,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [15:0]        wr_data,
  output int                 outstanding,
  output int                 failures
);
  import slp_pkg::*;

  localparam int SAMPLES_CAP = 4096;
  localparam int LEVELS_CAP  = 64;

  logic [15:0] gain_q;
  logic [6:0]  levels_q;
  logic [12:0] size_q;
  logic [1:0]  mode;
  logic [12:0] position;
  logic        holding;
  res_t        due_q[$];
  int          faults;

  function automatic logic [6:0] drive_level(logic signed [15:0] smp);
    longint s;
    longint g;
    longint n;
    longint x;
    longint lv;
    s = smp;
    g = gain_q;
    n = (levels_q > LEVELS_CAP) ? LEVELS_CAP : levels_q;
    x = (s * g + (longint'(1) << 27)) * n;
    if (x <= 0)
      return 7'd0;
    lv = (x + (longint'(1) << 27)) >>> 28;
    if (lv > n)
      lv = n;
    return lv[6:0];
  endfunction

  function automatic res_t play_step(logic [1:0] act, logic rdy, logic signed [15:0] smp);
    res_t        r;
    logic [12:0] span;
    r = '0;
    if (size_q == 13'd0)
      span = 13'd1;
    else if (size_q > SAMPLES_CAP)
      span = 13'(SAMPLES_CAP);
    else
      span = size_q;
    if (act == ACT_START) begin
      mode = ST_STALLED;
      position = span;
    end else if (act == ACT_STOP) begin
      if (mode == ST_STALLED || mode == ST_PLAYING)
        mode = ST_STOPPING;
    end else if (act == ACT_TICK && mode != ST_STOPPED) begin
      if (!holding || position >= span) begin
        if (holding) begin
          r.released = 1'b1;
          holding = 1'b0;
        end
        if (rdy) begin
          r.taken = 1'b1;
          holding = 1'b1;
          position = 13'd0;
          if (mode == ST_STALLED)
            mode = ST_PLAYING;
        end else if (mode == ST_STOPPING) begin
          mode = ST_STOPPED;
          r.idle = 1'b1;
        end else if (mode == ST_PLAYING) begin
          mode = ST_STALLED;
          r.idle = 1'b1;
        end
      end
      if (holding && position < span) begin
        r.level = drive_level(smp);
        r.used = 1'b1;
        position = position + 13'd1;
      end
    end
    r.state = mode;
    return r;
  endfunction

  function automatic string show(res_t r);
    return $sformatf("level %0d used %0b idle %0b taken %0b released %0b state %0d",
                     r.level, r.used, r.idle, r.taken, r.released, r.state);
  endfunction

  task automatic note_fault(string msg);
    faults++;
    if (faults <= 10)
      $display("%s", msg);
  endtask

  always @(posedge clk) begin
    res_t seen;
    res_t want;
    if (rst) begin
      gain_q = GAIN_RESET;
      levels_q = NUM_LEVELS_RESET;
      size_q = BUFFER_SAMPLES_RESET;
      mode = ST_STOPPED;
      position = 13'd0;
      holding = 1'b0;
      due_q.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_GAIN:           gain_q = wr_data;
          REG_NUM_LEVELS:     levels_q = wr_data[6:0];
          REG_BUFFER_SAMPLES: size_q = wr_data[12:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        seen.level = level;
        seen.used = sample_used;
        seen.idle = all_idle;
        seen.taken = buffer_taken;
        seen.released = buffer_released;
        seen.state = player_state;
        if (due_q.size() == 0) begin
          note_fault($sformatf("unexpected result at %0t: %s", $time, show(seen)));
        end else begin
          want = due_q.pop_front();
          if (seen.level !== want.level || seen.used !== want.used ||
              seen.idle !== want.idle || seen.taken !== want.taken ||
              seen.released !== want.released || seen.state !== want.state)
            note_fault($sformatf("mismatch at %0t: expected %s, got %s",
                                 $time, show(want), show(seen)));
        end
      end
      if (push && !full)
        due_q.push_back(play_step(action, buffer_ready, sample));
    end
    outstanding <= due_q.size();
    failures <= faults;
  end

endmodule

FILE: tb/sv/tb_sample_level_player.sv
`timescale 1ns / 100ps
module tb_sample_level_player;
  import slp_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         action = ACT_TICK;
  logic               buffer_ready = 1'b0;
  logic signed [15:0] sample = 16'sd0;
  logic               empty;
  logic               pop = 1'b0;
  logic [6:0]         level;
  logic               sample_used;
  logic               all_idle;
  logic               buffer_taken;
  logic               buffer_released;
  logic [1:0]         player_state;
  logic               wr_en = 1'b0;
  logic [1:0]         wr_index = REG_GAIN;
  logic [15:0]        wr_data = 16'd0;
  int                 outstanding;
  int                 failures;
  bit                 calm = 1'b0;

  sample_level_player dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .action(action), .buffer_ready(buffer_ready), .sample(sample),
    .empty(empty), .pop(pop),
    .level(level), .sample_used(sample_used), .all_idle(all_idle),
    .buffer_taken(buffer_taken), .buffer_released(buffer_released),
    .player_state(player_state),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  player_checker watcher (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .action(action), .buffer_ready(buffer_ready), .sample(sample),
    .empty(empty), .pop(pop),
    .level(level), .sample_used(sample_used), .all_idle(all_idle),
    .buffer_taken(buffer_taken), .buffer_released(buffer_released),
    .player_state(player_state),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .outstanding(outstanding), .failures(failures)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : result_side
    int run;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        run = $urandom_range(1, 19);
      end else begin
        pop <= 1'b1;
        run = $urandom_range(1, 40);
      end
      repeat (run) @(posedge clk);
    end
  end

  task automatic load_settings(logic [15:0] g, logic [6:0] n, logic [12:0] b);
    wr_en <= 1'b1;
    wr_index <= REG_GAIN;
    wr_data <= g;
    @(posedge clk);
    wr_index <= REG_NUM_LEVELS;
    wr_data <= {9'd0, n};
    @(posedge clk);
    wr_index <= REG_BUFFER_SAMPLES;
    wr_data <= {3'd0, b};
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // hold the request until accepted, then maybe idle for a burst
  task automatic send(logic [1:0] act, logic rdy, logic signed [15:0] smp);
    push <= 1'b1;
    action <= act;
    buffer_ready <= rdy;
    sample <= smp;
    do @(posedge clk); while (full);
    if (!calm && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_sample();
    int v;
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: begin
        v = $urandom_range(0, 64);
        return 16'(v - 32);
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_action();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 72)
      return ACT_TICK;
    else if (roll < 82)
      return ACT_START;
    else if (roll < 94)
      return ACT_STOP;
    else
      return ACT_SPARE;
  endfunction

  initial begin : request_side
    int ready_pct;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    load_settings(GAIN_RESET, NUM_LEVELS_RESET, 13'd3);

    send(ACT_TICK, 1'b1, 16'sh1234);
    send(ACT_SPARE, 1'b1, 16'sh0000);
    send(ACT_STOP, 1'b0, 16'sh0000);
    send(ACT_START, 1'b0, 16'sh0000);
    send(ACT_TICK, 1'b0, 16'sh4000);
    send(ACT_TICK, 1'b1, 16'sh8000);
    send(ACT_TICK, 1'b0, 16'sh7FFF);
    send(ACT_TICK, 1'b0, 16'sh0000);
    send(ACT_TICK, 1'b1, -16'sd1);
    send(ACT_TICK, 1'b0, 16'sh4000);
    send(ACT_START, 1'b1, 16'sh0000);
    send(ACT_TICK, 1'b0, 16'sh2000);
    send(ACT_TICK, 1'b1, -16'sh2000);
    send(ACT_TICK, 1'b0, 16'sh0001);
    send(ACT_TICK, 1'b0, 16'sh6000);
    send(ACT_TICK, 1'b0, 16'sh1000);
    send(ACT_TICK, 1'b1, 16'sh7FFF);
    send(ACT_STOP, 1'b1, 16'sh0000);
    send(ACT_STOP, 1'b1, 16'sh0000);
    send(ACT_TICK, 1'b0, 16'sh8000);
    send(ACT_TICK, 1'b0, 16'sh0800);
    send(ACT_TICK, 1'b0, 16'sh0000);
    send(ACT_TICK, 1'b1, 16'sh3000);
    send(ACT_START, 1'b0, 16'sh0000);
    send(ACT_TICK, 1'b1, 16'sh5555);

    for (int p = 0; p < 8; p++) begin
      settle();
      if (p == 7)
        calm = 1'b1;
      case (p)
        0: load_settings(16'd4096, 7'd64, 13'd1);
        1: load_settings(16'd0, 7'd1, 13'd0);
        2: load_settings(16'd65535, 7'd127, 13'd5);
        3: load_settings(16'd2048, 7'd0, 13'd2);
        4: load_settings(16'($urandom), 7'd64, 13'd8191);
        5: load_settings(16'd40960, 7'd5, 13'd3);
        6: load_settings(16'($urandom), 7'($urandom_range(1, 64)), 13'($urandom_range(1, 6)));
        default: load_settings(GAIN_RESET, NUM_LEVELS_RESET, BUFFER_SAMPLES_RESET);
      endcase
      ready_pct = $urandom_range(40, 95);
      for (int i = 0; i < 91; i++)
        send(pick_action(), $urandom_range(0, 99) < ready_pct, pick_sample());
    end

    settle();
    repeat (10) @(posedge clk);
    if (failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
